/* design/xr128_pkg.sv */
// Shared types and constants for the ranged xorshift128 generator.
// Used by xr128_gen, xr128_rem and xorshift128_ranged_generator_core.
`timescale 1ns / 1ps
`default_nettype none

package xr128_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CNT_W  = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS = 4;

  // Seed offsets, newest word first.
  localparam logic [WORD_W-1:0] SEED_OFS0 = 32'd3;
  localparam logic [WORD_W-1:0] SEED_OFS1 = 32'd5;
  localparam logic [WORD_W-1:0] SEED_OFS2 = 32'd7;
  localparam logic [WORD_W-1:0] SEED_OFS3 = 32'd11;

  // Xorshift shift amounts.
  localparam int unsigned SHL_A = 11;
  localparam int unsigned SHR_B = 8;
  localparam int unsigned SHR_C = 19;

  localparam logic OP_RAW    = 1'b0;
  localparam logic OP_RANGED = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
  } rem_ctrl_t;

  typedef struct packed {
    logic done;
  } rem_stat_t;

endpackage

`default_nettype wire

/* design/xr128_gen.sv */
// Xorshift128 state: four 32-bit words, seed loading and one-step advance.
// Depends on xr128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xr128_gen (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 seed_load_i,
  input  xr128_pkg::word_t    seed_i,
  input  wire                 step_i,
  output xr128_pkg::word_t    next_word_o
);
  import xr128_pkg::*;

  word_t words_q [NUM_WORDS];
  word_t t1, t2;

  always_comb begin
    t1 = words_q[3] ^ (words_q[3] << SHL_A);
    t2 = t1 ^ (t1 >> SHR_B);
    next_word_o = t2 ^ words_q[0] ^ (words_q[0] >> SHR_C);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q[0] <= SEED_OFS0;
      words_q[1] <= SEED_OFS1;
      words_q[2] <= SEED_OFS2;
      words_q[3] <= SEED_OFS3;
    end else if (seed_load_i) begin
      words_q[0] <= seed_i + SEED_OFS0;
      words_q[1] <= seed_i + SEED_OFS1;
      words_q[2] <= seed_i + SEED_OFS2;
      words_q[3] <= seed_i + SEED_OFS3;
    end else if (step_i) begin
      words_q[3] <= words_q[2];
      words_q[2] <= words_q[1];
      words_q[1] <= words_q[0];
      words_q[0] <= next_word_o;
    end
  end

endmodule

`default_nettype wire

/* design/xr128_rem.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on xr128_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xr128_rem (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  xr128_pkg::rem_ctrl_t ctrl_i,
  input  xr128_pkg::word_t     dividend_i,
  input  xr128_pkg::word_t     divisor_i,
  output xr128_pkg::rem_stat_t stat_o,
  output xr128_pkg::word_t     rem_o
);
  import xr128_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WORD_W - 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  word_t            dvd_q, dvd_d;
  word_t            dvs_q, dvs_d;
  word_t            rem_q, rem_d;
  logic [WORD_W:0]  trial;
  logic [WORD_W:0]  diff;
  logic             last;

  always_comb begin
    trial  = {rem_q, dvd_q[WORD_W-1]};
    diff   = trial - {1'b0, dvs_q};
    last   = busy_q && (cnt_q == LAST_CNT);
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so the kept value fits a word.
      if (!diff[WORD_W]) begin
        rem_d = diff[WORD_W-1:0];
      end else begin
        rem_d = trial[WORD_W-1:0];
      end
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign stat_o.done = last;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

/* design/xorshift128_ranged_generator_core.sv */
// Top level of the ranged xorshift128 generator: handshakes, control FSM, output register.
// Depends on xr128_pkg, xr128_gen and xr128_rem.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted transaction advances the xorshift128 state once and returns one value.
// A raw request, or a ranged request whose span high - low + 1 wraps to zero, moves from
// acceptance to the ST_OUT state and is written to the output register once that is free;
// the state then returns to ST_IDLE and the next request can be taken. A ranged request
// first runs the remainder through a bit-serial divider in ST_DIV, one dividend bit per
// cycle, and then passes through ST_OUT to the output register. One request is
// in flight at a time; the next one is taken as soon as its result sits in the output
// register, even if that result is stalled. Writing the seed reloads the state and is
// accepted only while no request is in flight; a seed write offered together with a
// request is taken first and the request is stalled while the write is offered.
module xorshift128_ranged_generator_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  xr128_pkg::word_t    seed_value_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire                 op_i,
  input  xr128_pkg::word_t    range_low_i,
  input  xr128_pkg::word_t    range_high_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output xr128_pkg::word_t    value_o
);
  import xr128_pkg::*;

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  word_t     value_q, value_d;
  word_t     word_q, word_d;
  word_t     low_q, low_d;
  logic      use_rem_q, use_rem_d;
  logic      in_accept;
  logic      cfg_write;
  logic      out_free;
  word_t     span;
  word_t     next_word;
  word_t     rem;
  rem_ctrl_t rem_ctrl;
  rem_stat_t rem_stat;

  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_write = cfg_valid_i && cfg_ready_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign span      = range_high_i - range_low_i + 1'b1;

  xr128_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_load_i (cfg_write),
    .seed_i      (seed_value_i),
    .step_i      (in_accept),
    .next_word_o (next_word)
  );

  xr128_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rem_ctrl),
    .dividend_i (next_word),
    .divisor_i  (span),
    .stat_o     (rem_stat),
    .rem_o      (rem)
  );

  always_comb begin
    state_d        = state_q;
    word_d         = word_q;
    low_d          = low_q;
    use_rem_d      = use_rem_q;
    value_d        = value_q;
    out_valid_d    = out_valid_q;
    rem_ctrl.start = 1'b0;
    in_stall_o     = 1'b1;
    cfg_ready_o    = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        // A pending seed write goes first so the request sees the reloaded state.
        in_stall_o  = cfg_valid_i;
        cfg_ready_o = 1'b1;
        if (in_accept) begin
          word_d    = next_word;
          low_d     = range_low_i;
          use_rem_d = (op_i == OP_RANGED) && (span != '0);
          if ((op_i == OP_RANGED) && (span != '0)) begin
            rem_ctrl.start = 1'b1;
            state_d        = ST_DIV;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          value_d     = use_rem_q ? (low_q + rem) : word_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    low_q     <= low_d;
    use_rem_q <= use_rem_d;
    value_q   <= value_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

endmodule

`default_nettype wire

/* design/xr128_checker.sv */
// Port-level checker for xorshift128_ranged_generator_core, with its bind statement.
// Depends on xr128_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module xr128_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 cfg_valid_i,
  input wire                 cfg_ready_o,
  input wire                 in_valid_i,
  input wire                 in_stall_o,
  input wire                 out_valid_o,
  input wire                 out_stall_i,
  input xr128_pkg::word_t    value_o
);

  // Only one transaction is in flight: the input side closes right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while a transaction was already in flight");

  // The seed cannot be rewritten while a transaction is being worked on.
  a_no_cfg_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !cfg_ready_o)
    else $error("configuration port open during a transaction");

  // A new result only appears after the block was busy working on it.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in flight");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_o)))
    else $error("stalled result changed or dropped");

endmodule

bind xorshift128_ranged_generator_core xr128_checker u_xr128_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o)
);

`default_nettype wire

/* bench/xorshift_value_checker.sv */
// Checker for the ranged xorshift128 generator: watches the seed, request and result
// channels, predicts every generated value and compares it. Depends on xr128_pkg.
`timescale 1ns / 1ps

module xorshift_value_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  xr128_pkg::word_t  seed_value_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              op_i,
  input  xr128_pkg::word_t  range_low_i,
  input  xr128_pkg::word_t  range_high_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  xr128_pkg::word_t  value_i,
  input  logic              end_of_run_i,
  output int                pending_o,
  output int                fail_count_o
);
  import xr128_pkg::*;

  // Word 0 (newest) sits in the low 32 bits, word 3 (oldest) in the high 32 bits.
  logic [127:0] gen_state;
  word_t        expected_values[$];
  word_t        oldest;
  int           mismatches = 0;
  logic         leftovers_done;

  assign fail_count_o = mismatches;

  function automatic logic [127:0] seeded_state(input word_t s);
    return {s + SEED_OFS3, s + SEED_OFS2, s + SEED_OFS1, s + SEED_OFS0};
  endfunction

  function automatic logic [127:0] next_gen_state(input logic [127:0] st);
    word_t t;
    word_t w;
    t = st[127:96];
    w = st[31:0];
    t = t ^ (t << SHL_A);
    t = t ^ (t >> SHR_B);
    t = t ^ w ^ (w >> SHR_C);
    return {st[95:64], st[63:32], w, t};
  endfunction

  // A span that wraps to zero leaves the raw word untouched, low is not added.
  function automatic word_t ranged_value(input logic op, input word_t lo, input word_t hi,
                                         input word_t raw);
    word_t span;
    span = hi - lo + 32'd1;
    if (op == OP_RANGED && span != '0) begin
      return (raw % span) + lo;
    end
    return raw;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    $display("MISMATCH at %0t ns: %s: got %08h, expected %08h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_state = seeded_state('0);
      expected_values.delete();
      leftovers_done = 1'b0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        gen_state = seeded_state(seed_value_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_values.size() == 0) begin
          report_mismatch("result with no request waiting", value_i, '0);
        end else begin
          oldest = expected_values.pop_front();
          if (value_i !== oldest) begin
            report_mismatch("value", value_i, oldest);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        gen_state = next_gen_state(gen_state);
        expected_values.push_back(ranged_value(op_i, range_low_i, range_high_i,
                                               gen_state[31:0]));
      end
      if (end_of_run_i && !leftovers_done) begin
        leftovers_done = 1'b1;
        if (expected_values.size() != 0) begin
          report_mismatch("requests left without a result",
                          word_t'(expected_values.size()), '0);
        end
      end
      pending_o <= expected_values.size();
    end
  end

endmodule

/* bench/tb.sv */
// Top of the ranged xorshift128 generator testbench: clock, reset, seed writes,
// request stimulus and result back-pressure. Depends on xr128_pkg and xorshift_value_checker.
`timescale 1ns / 1ps

module tb;
  import xr128_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    K_RAW,
    K_NARROW,
    K_WIDE,
    K_ZERO_SPAN,
    K_POW2,
    K_INVERTED,
    K_SINGLE
  } req_kind_e;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  cfg_valid = 1'b0;
  word_t seed = '0;
  logic  in_valid = 1'b0;
  logic  op = OP_RAW;
  word_t range_low = '0;
  word_t range_high = '0;
  logic  out_stall = 1'b0;
  logic  end_of_run = 1'b0;
  logic  hold_kick = 1'b0;

  logic  cfg_ready;
  logic  in_stall;
  logic  out_valid;
  word_t value;
  int    pending;
  int    fail_count;

  int    idle_pct = 0;
  int    stall_pct = 0;
  int    hold_left = 0;

  always #5 clk = ~clk;

  xorshift128_ranged_generator_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .seed_value_i (seed),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_o      (value)
  );

  xorshift_value_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .seed_value_i (seed),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (op),
    .range_low_i  (range_low),
    .range_high_i (range_high),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .value_i      (value),
    .end_of_run_i (end_of_run),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Result back-pressure; a kick from the request side starts one long hold-off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_kick) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Valid stays high between back-to-back transactions; only the payload moves.
  task automatic send_request(input logic req_op, input word_t lo, input word_t hi);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= req_op;
    range_low  <= lo;
    range_high <= hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random_request();
    req_kind_e kind;
    word_t     lo;
    word_t     hi;
    kind = req_kind_e'($urandom_range(0, int'(K_SINGLE)));
    lo   = $urandom;
    hi   = $urandom;
    case (kind)
      K_RAW:       send_request(OP_RAW, lo, hi);
      K_NARROW:    send_request(OP_RANGED, lo, lo + $urandom_range(0, 255));
      K_WIDE:      send_request(OP_RANGED, lo, hi);
      K_ZERO_SPAN: send_request(OP_RANGED, lo, lo - 32'd1);
      K_POW2:      send_request(OP_RANGED, lo, lo + ((32'd1 << $urandom_range(0, 31)) - 1));
      K_INVERTED:  send_request(OP_RANGED, lo, lo - 32'd2 - $urandom_range(0, 1000));
      default:     send_request(OP_RANGED, lo, lo);
    endcase
  endtask

  // The checker's pending count is registered, hence the short settle.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_seed(input word_t s);
    wait_all_results();
    cfg_valid <= 1'b1;
    seed      <= s;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input word_t s, input int n_items);
    write_seed(s);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    repeat (n_items) send_random_request();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct  = 27;
    stall_pct = 77;

    // Directed requests on the reset state: raw, range extremes and wrapping spans.
    send_request(OP_RAW, '0, '0);
    send_request(OP_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_RANGED, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_RANGED, 32'h0000_0005, 32'h0000_0004);
    send_request(OP_RANGED, 32'h0000_0001, 32'h0000_0000);
    send_request(OP_RANGED, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_RANGED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_RANGED, 32'h0000_0000, 32'h0000_0001);
    send_request(OP_RANGED, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(OP_RANGED, 32'h0000_0064, 32'h0000_000A);
    send_request(OP_RANGED, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_RANGED, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(OP_RANGED, 32'h8000_0000, 32'hFFFF_FFFF);
    send_request(OP_RANGED, 32'h0000_0000, 32'hFFFF_FFFE);
    send_request(OP_RANGED, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(OP_RANGED, 32'h8000_0000, 32'h7FFF_FFFE);
    send_request(OP_RANGED, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(OP_RANGED, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(OP_RAW, 32'h1234_5678, 32'h0000_0000);
    send_request(OP_RANGED, 32'h0000_0003, 32'h0000_0009);

    run_random_phase(32'hFFFF_FFFF, 233);

    idle_pct  = 77;
    stall_pct = 27;
    run_random_phase($urandom, 233);

    idle_pct  = 0;
    stall_pct = 0;
    run_random_phase('0, 234);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
